FILE: rtl/core/pps_pkg.sv
// Package for the particle pool physics step unit.
// Holds sizes, command codes, the particle record and the word layouts.
// No dependencies.
package pps_pkg;

  localparam int unsigned NumSlots  = 64;
  localparam int unsigned SlotW     = 6;
  localparam int unsigned CountW    = 7;

  localparam logic [2:0] CmdClear   = 3'd0;
  localparam logic [2:0] CmdCreate  = 3'd1;
  localparam logic [2:0] CmdAdvance = 3'd2;
  localparam logic [2:0] CmdCull    = 3'd3;
  localparam logic [2:0] CmdRead    = 3'd4;

  localparam logic [1:0] RegGravity = 2'd0;
  localparam logic [1:0] RegWidth   = 2'd1;
  localparam logic [1:0] RegHeight  = 2'd2;

  localparam int unsigned InW  = 3 + 20 + 20 + 16 + 16 + 16 + 24 + 12 + 2 + 10 + 10 + 6;
  localparam int unsigned InBytesW  = ((InW + 7) / 8) * 8;
  localparam int unsigned OutW = 6 + 1 + 20 + 20 + 16 + 16 + 17 + 24 + 2 + 10 + 10 + 7;
  localparam int unsigned OutBytesW = ((OutW + 7) / 8) * 8;

  // Dynamic fields, cleared by the clear command.
  typedef struct packed {
    logic signed [19:0] x;
    logic signed [19:0] y;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [16:0] life;
    logic [23:0]        color;
    logic [1:0]         kind;
  } dyn_t;

  // Static fields, kept across clear.
  typedef struct packed {
    logic [11:0] mass;
    logic [9:0]  wid;
    logic [9:0]  hgt;
  } stat_t;

  typedef struct packed {
    logic [5:0]         slot;
    logic               ok;
    logic signed [19:0] pos_x;
    logic signed [19:0] pos_y;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [16:0] life_left;
    logic [23:0]        color;
    logic [1:0]         kind;
    logic [9:0]         width;
    logic [9:0]         height;
    logic [6:0]         live_count;
  } result_t;

endpackage

FILE: rtl/core/pps_slot_ram.sv
// Slot memory of the particle pool: one write and one registered read port.
// Generic; no package dependency.
module pps_slot_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

FILE: rtl/core/pps_update.sv
// Per-slot physics: advance (Euler step) and cull/bounce arithmetic.
// Depends on pps_pkg.
module pps_update (
  input  pps_pkg::dyn_t        dyn_i,
  input  pps_pkg::stat_t       stat_i,
  input  logic signed [20:0]   dv_i,
  input  logic [11:0]          scr_w_i,
  input  logic [11:0]          scr_h_i,
  output pps_pkg::dyn_t        adv_o,
  output pps_pkg::dyn_t        cull_o,
  output logic                 kill_o
);
  import pps_pkg::*;

  logic signed [17:0] life_s;
  logic signed [20:0] x_s, y_s;
  logic signed [21:0] vy_s;
  logic signed [16:0] mag;
  logic signed [15:0] mag_c;
  logic signed [21:0] right;

  always_comb begin
    adv_o  = dyn_i;
    life_s = {dyn_i.life[16], dyn_i.life} - 18'sd1;
    adv_o.life = (life_s < -18'sd65536) ? -17'sd65536 : life_s[16:0];
    x_s = {dyn_i.x[19], dyn_i.x} + 21'(dyn_i.vx);
    y_s = {dyn_i.y[19], dyn_i.y} + 21'(dyn_i.vy);
    adv_o.x = (x_s > 21'sd524287) ? 20'sd524287 :
              (x_s < -21'sd524288) ? -20'sd524288 : x_s[19:0];
    adv_o.y = (y_s > 21'sd524287) ? 20'sd524287 :
              (y_s < -21'sd524288) ? -20'sd524288 : y_s[19:0];
    // Add the full gravity delta, then clamp once.
    vy_s = 22'(dyn_i.vy) + 22'(dv_i);
    adv_o.vy = (vy_s > 22'sd32767) ? 16'sd32767 :
               (vy_s < -22'sd32768) ? -16'sd32768 : vy_s[15:0];

    cull_o = dyn_i;
    mag    = dyn_i.vx[15] ? -{1'b1, dyn_i.vx} : {1'b0, dyn_i.vx};
    mag_c  = (mag > 17'sd32767) ? 16'sd32767 : mag[15:0];
    right  = 22'(dyn_i.x) + $signed({2'b0, stat_i.wid, 8'b0});
    if (dyn_i.kind != 2'd0) begin
      if (right > $signed({2'b0, scr_w_i, 8'b0})) cull_o.vx = -mag_c;
      if (dyn_i.x[19]) cull_o.vx = mag_c;
    end
    kill_o = ($signed({{2{dyn_i.y[19]}}, dyn_i.y}) > $signed({2'b0, scr_h_i, 8'b0}))
             || dyn_i.life[16];
  end
endmodule

FILE: rtl/core/particle_pool_physics_step_unit.sv
// Top level of the particle pool physics step unit.
// Depends on pps_pkg, pps_slot_ram and pps_update.
//
//  channel | dir | contents
//  s_axis  | in  | command word (tdata: cmd, new_x, new_y, new_vx, new_vy, new_life,
//          |     |   new_color, new_mass, new_kind, new_width, new_height, read_slot)
//  m_axis  | out | result word (tdata: slot, ok, pos_x, pos_y, vel_x, vel_y,
//          |     |   life_left, color, kind, width, height, live_count)
//  cfg     | in  | register write (0 gravity, 1 screen_width, 2 screen_height)
//
// Clear, advance and cull sweep the pool one slot per cycle through the slot
// memory read/modify/write loop: a setup state, the reads of all 64 slots, a drain
// of the pipe and the output state, after which the result is valid.
// Create and read go through the read, finish and output states.
// The gravity product gravity*mass is computed once per slot in a register stage.
// Reset: control, live bits and per-slot written flags clear at once; a slot never
// written reads back zero dynamic fields through its flag, with no clearing pass.
// Stalls: one word is worked at a time; a finished result waits in the output
// register, and the next word is taken only once that result is accepted.
module particle_pool_physics_step_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // cmd[2:0] new_x[22:3] new_y[42:23] new_vx[58:43] new_vy[74:59] new_life[90:75]
  // new_color[114:91] new_mass[126:115] new_kind[128:127] new_width[138:129]
  // new_height[148:139] read_slot[154:149]
  input  logic [pps_pkg::InBytesW-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // slot[5:0] ok[6] pos_x[26:7] pos_y[46:27] vel_x[62:47] vel_y[78:63]
  // life_left[95:79] color[119:96] kind[121:120] width[131:122] height[141:132]
  // live_count[148:142]
  output logic [pps_pkg::OutBytesW-1:0] m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [15:0]                   cfg_wdata_i
);
  import pps_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRd   = 3'd1;  // read issued for single-slot command, setup for a sweep
  localparam logic [2:0] StFin  = 3'd2;  // single-slot data back
  localparam logic [2:0] StSwp  = 3'd3;  // sweep over the pool
  localparam logic [2:0] StOut  = 3'd4;  // load output register

  // Configuration registers.
  logic signed [15:0] grav_q;
  logic [11:0] scr_w_q, scr_h_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_q  <= 16'sd26;
      scr_w_q <= 12'd640;
      scr_h_q <= 12'd480;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegGravity: grav_q  <= cfg_wdata_i;
        RegWidth:   scr_w_q <= cfg_wdata_i[11:0];
        RegHeight:  scr_h_q <= cfg_wdata_i[11:0];
        default: ;
      endcase
    end
  end

  // Command register.
  logic [2:0]         cmd_q;
  logic signed [19:0] nx_q, ny_q;
  logic signed [15:0] nvx_q, nvy_q;
  logic [15:0]        nlife_q;
  logic [23:0]        ncol_q;
  logic [11:0]        nmass_q;
  logic [1:0]         nkind_q;
  logic [9:0]         nwid_q, nhgt_q;
  logic [5:0]         rslot_q;

  logic [2:0]  st_q, st_d;
  logic [NumSlots-1:0] live_q;
  logic [NumSlots-1:0] wr_q;      // slot created since reset
  logic [SlotW:0] cnt_q;          // sweep read pointer
  logic         ovalid_q;
  result_t      res_q;
  logic [5:0]   cslot;
  logic         cfound;

  // Memories.
  logic          dyn_we, stat_we;
  logic [SlotW-1:0] dyn_wa, rd_a;
  dyn_t          dyn_wd, dyn_rd;
  stat_t         stat_wd, stat_rd;

  pps_slot_ram #(.Width($bits(dyn_t)), .Depth(NumSlots)) u_dyn (
    .clk_i, .we_i(dyn_we), .waddr_i(dyn_wa), .wdata_i(dyn_wd),
    .raddr_i(rd_a), .rdata_o(dyn_rd)
  );
  pps_slot_ram #(.Width($bits(stat_t)), .Depth(NumSlots)) u_stat (
    .clk_i, .we_i(stat_we), .waddr_i(cslot), .wdata_i(stat_wd),
    .raddr_i(rd_a), .rdata_o(stat_rd)
  );

  // Lowest free slot.
  always_comb begin
    cslot  = '0;
    cfound = 1'b0;
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (!live_q[i]) begin
        cslot  = SlotW'(i);
        cfound = 1'b1;
      end
    end
  end

  // Gravity stage: register the scaled delta and the read data per slot.
  logic signed [28:0] prod;
  logic signed [20:0] dv_q;
  logic signed [20:0] dv_full;
  dyn_t               rd_q;
  logic               rlive_q;
  assign prod    = grav_q * $signed({1'b0, stat_rd.mass});
  assign dv_full = 21'(prod >>> 8);   // floor
  always_ff @(posedge clk_i) begin
    dv_q  <= dv_full;
    rd_q  <= dyn_rd;
  end

  // Stage-two update of the previously read slot (two-stage pipe, distinct slots).
  logic [SlotW-1:0] s1_ptr_q;
  logic             s1_v_q;
  stat_t            st1_q;
  always_ff @(posedge clk_i) st1_q <= stat_rd;

  dyn_t adv, cul;
  logic kill;
  pps_update u_upd (
    .dyn_i(rd_q), .stat_i(st1_q), .dv_i(dv_q), .scr_w_i(scr_w_q),
    .scr_h_i(scr_h_q), .adv_o(adv), .cull_o(cul), .kill_o(kill)
  );

  logic in_acc;
  assign s_axis_tready = (st_q == StIdle) && !(ovalid_q && !m_axis_tready);
  assign in_acc = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q   <= s_axis_tdata[2:0];
      nx_q    <= s_axis_tdata[22:3];
      ny_q    <= s_axis_tdata[42:23];
      nvx_q   <= s_axis_tdata[58:43];
      nvy_q   <= s_axis_tdata[74:59];
      nlife_q <= s_axis_tdata[90:75];
      ncol_q  <= s_axis_tdata[114:91];
      nmass_q <= s_axis_tdata[126:115];
      nkind_q <= s_axis_tdata[128:127];
      nwid_q  <= s_axis_tdata[138:129];
      nhgt_q  <= s_axis_tdata[148:139];
      rslot_q <= s_axis_tdata[154:149];
    end
  end

  logic sweeping;
  assign sweeping = (cmd_q == CmdClear) || (cmd_q == CmdAdvance) || (cmd_q == CmdCull);
  assign rd_a = (st_q == StSwp) ? cnt_q[SlotW-1:0] : rslot_q;

  // Read data of a never-written slot shows as zero.
  dyn_t rdat;
  assign rdat = wr_q[rslot_q] ? dyn_rd : '0;

  // Writes: clear zeroing, sweep write-back at stage two, or create.
  always_comb begin
    dyn_we  = 1'b0;
    dyn_wa  = s1_ptr_q;
    dyn_wd  = rd_q;
    stat_we = 1'b0;
    stat_wd = '{mass: nmass_q, wid: nwid_q, hgt: nhgt_q};
    if (st_q == StSwp && cmd_q == CmdClear && !cnt_q[SlotW]) begin
      dyn_we = 1'b1;
      dyn_wa = cnt_q[SlotW-1:0];
      dyn_wd = '0;
    end else if (s1_v_q && live_q[s1_ptr_q]) begin
      dyn_we = (cmd_q == CmdAdvance) || (cmd_q == CmdCull);
      dyn_wd = (cmd_q == CmdAdvance) ? adv : cul;
    end else if (st_q == StRd && cmd_q == CmdCreate && cfound) begin
      dyn_we  = 1'b1;
      dyn_wa  = cslot;
      dyn_wd  = '{x: nx_q, y: ny_q, vx: nvx_q, vy: nvy_q,
                  life: {1'b0, nlife_q}, color: ncol_q, kind: nkind_q};
      stat_we = 1'b1;
    end
  end

  // Delay pipe for the sweep pointer: cnt is the read address, s0 follows the read data, s1 the update.
  logic [SlotW-1:0] s0_ptr_q;
  logic             s0_v_q;

  logic [CountW-1:0] pop;
  always_comb begin
    pop = '0;
    for (int i = 0; i < NumSlots; i++) pop = pop + CountW'(live_q[i]);
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle: if (in_acc) st_d = StRd;
      StRd:   st_d = sweeping ? StSwp : StFin;
      StFin:  st_d = StOut;
      StSwp:  if (cnt_q[SlotW] && !s0_v_q && !s1_v_q) st_d = StOut;
      StOut:  st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= StIdle;
      live_q   <= '0;
      wr_q     <= '0;
      cnt_q    <= '0;
      s0_v_q   <= 1'b0;
      s1_v_q   <= 1'b0;
      s0_ptr_q <= '0;
      s1_ptr_q <= '0;
      ovalid_q <= 1'b0;
      res_q    <= '0;
    end else begin
      st_q <= st_d;
      if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
      s0_v_q   <= (st_q == StSwp) && !cnt_q[SlotW];
      s0_ptr_q <= cnt_q[SlotW-1:0];
      s1_v_q   <= s0_v_q;
      s1_ptr_q <= s0_ptr_q;
      if (st_q == StRd) cnt_q <= '0;
      if (st_q == StSwp && !cnt_q[SlotW]) cnt_q <= cnt_q + 1'b1;
      if (st_q == StRd && cmd_q == CmdClear) live_q <= '0;
      if (st_q == StRd && cmd_q == CmdCreate && cfound) begin
        live_q[cslot] <= 1'b1;
        wr_q[cslot]   <= 1'b1;
      end
      if (s1_v_q && cmd_q == CmdCull && live_q[s1_ptr_q] && kill)
        live_q[s1_ptr_q] <= 1'b0;
      if (st_q == StRd) begin
        if (cmd_q == CmdCreate && cfound) begin
          res_q <= '{slot: cslot, ok: 1'b1, default: '0};
        end else begin
          res_q <= '0;
        end
      end
      if (st_q == StFin && cmd_q == CmdRead) begin
        res_q.slot <= rslot_q;
        res_q.ok   <= live_q[rslot_q];
        res_q.pos_x <= rdat.x;
        res_q.pos_y <= rdat.y;
        res_q.vel_x <= rdat.vx;
        res_q.vel_y <= rdat.vy;
        res_q.life_left <= rdat.life;
        res_q.color <= rdat.color;
        res_q.kind  <= rdat.kind;
        res_q.width <= stat_rd.wid;
        res_q.height <= stat_rd.hgt;
      end
      if (st_q == StOut) begin
        res_q.live_count <= pop;
        ovalid_q <= 1'b1;
      end
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {{(OutBytesW - OutW){1'b0}},
    res_q.live_count, res_q.height, res_q.width, res_q.kind, res_q.color,
    res_q.life_left, res_q.vel_y, res_q.vel_x, res_q.pos_y, res_q.pos_x,
    res_q.ok, res_q.slot};
endmodule

FILE: rtl/core/pps_checker.sv
// Port-level checker for the particle pool physics step unit.
// Depends on pps_pkg; bound to the top level below.
module pps_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [pps_pkg::OutBytesW-1:0] m_axis_tdata
);
  import pps_pkg::*;

  // Hold a stalled result.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // live_count never exceeds the pool size.
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[148:142] <= CountW'(NumSlots))
    else $error("live_count above pool size");

  // One word at a time: no new word right after one was taken.
  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("word taken while busy");

  // A result with ok set (create, or read of a live slot) has a nonzero live_count.
  a_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[6] |-> m_axis_tdata[148:142] != '0)
    else $error("ok with empty pool");
endmodule

bind particle_pool_physics_step_unit pps_checker u_pps_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for particle_pool_physics_step_unit.
// Drives command words with random gaps, predicts each result word from its own
// pool model and checks every result field. Depends on pps_pkg and the RTL.
module tb_top;
  import pps_pkg::*;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned ItemTarget = 1600;

  // One command word, split into its fields.
  typedef struct {
    logic [2:0]         cmd;
    logic signed [19:0] x;
    logic signed [19:0] y;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic [15:0]        life;
    logic [23:0]        color;
    logic [11:0]        mass;
    logic [1:0]         kind;
    logic [9:0]         wid;
    logic [9:0]         hgt;
    logic [5:0]         rd;
  } cmd_word_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InBytesW-1:0]  s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutBytesW-1:0] m_axis_tdata;
  logic                 cfg_we_i;
  logic [1:0]           cfg_idx_i;
  logic [15:0]          cfg_wdata_i;

  particle_pool_physics_step_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Bench-side copy of the pool and of the registers.
  logic               slot_live [NumSlots];
  logic signed [19:0] slot_x    [NumSlots];
  logic signed [19:0] slot_y    [NumSlots];
  logic signed [15:0] slot_vx   [NumSlots];
  logic signed [15:0] slot_vy   [NumSlots];
  longint             slot_life [NumSlots];
  logic [23:0]        slot_color[NumSlots];
  logic [11:0]        slot_mass [NumSlots];
  logic [1:0]         slot_kind [NumSlots];
  logic [9:0]         slot_wid  [NumSlots];
  logic [9:0]         slot_hgt  [NumSlots];
  logic signed [15:0] gravity_q;
  logic [11:0]        scr_w;
  logic [11:0]        scr_h;

  cmd_word_t word_q[$];        // command words waiting for the driver
  result_t   result_q[$];      // predicted result words, oldest first
  cmd_word_t on_bus;           // word currently offered on s_axis
  int        errors;
  int        issued;
  bit        calm;             // no idling in the closing stretch
  int        send_gap;
  int        recv_gap;
  int unsigned cycles;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic logic [InBytesW-1:0] pack_word(cmd_word_t w);
    logic [InBytesW-1:0] d;
    d = '0;
    d[2:0]     = w.cmd;
    d[22:3]    = w.x;
    d[42:23]   = w.y;
    d[58:43]   = w.vx;
    d[74:59]   = w.vy;
    d[90:75]   = w.life;
    d[114:91]  = w.color;
    d[126:115] = w.mass;
    d[128:127] = w.kind;
    d[138:129] = w.wid;
    d[148:139] = w.hgt;
    d[154:149] = w.rd;
    return d;
  endfunction

  function automatic void clear_pool();
    for (int p = 0; p < NumSlots; p++) begin
      slot_live[p] = 1'b0; slot_x[p] = '0; slot_y[p] = '0; slot_vx[p] = '0;
      slot_vy[p] = '0; slot_life[p] = 0; slot_color[p] = '0; slot_kind[p] = '0;
    end
  endfunction

  // Apply one accepted command to the pool copy and queue its result word.
  function automatic void run_command(cmd_word_t w);
    result_t r;
    longint  prod, mag, hlim, wlim;
    int      n;
    r = '0;
    case (w.cmd)
      CmdClear: clear_pool();
      CmdCreate: begin
        for (int p = 0; p < NumSlots; p++) begin
          if (!slot_live[p]) begin
            slot_live[p] = 1'b1; slot_x[p] = w.x; slot_y[p] = w.y;
            slot_vx[p] = w.vx; slot_vy[p] = w.vy; slot_life[p] = longint'(w.life);
            slot_color[p] = w.color; slot_mass[p] = w.mass; slot_kind[p] = w.kind;
            slot_wid[p] = w.wid; slot_hgt[p] = w.hgt;
            r.slot = 6'(p); r.ok = 1'b1;
            break;
          end
        end
      end
      CmdAdvance: begin
        for (int p = 0; p < NumSlots; p++) begin
          if (!slot_live[p]) continue;
          slot_life[p] = clip(slot_life[p] - 1, -65536, 65535);
          slot_x[p] = 20'(clip(longint'(slot_x[p]) + slot_vx[p], -524288, 524287));
          slot_y[p] = 20'(clip(longint'(slot_y[p]) + slot_vy[p], -524288, 524287));
          // arithmetic shift of the product floors toward minus infinity
          prod = longint'(gravity_q) * longint'({1'b0, slot_mass[p]});
          slot_vy[p] = 16'(clip(longint'(slot_vy[p]) + (prod >>> 8), -32768, 32767));
        end
      end
      CmdCull: begin
        hlim = longint'(scr_h) * 256;
        wlim = longint'(scr_w) * 256;
        for (int p = 0; p < NumSlots; p++) begin
          if (!slot_live[p]) continue;
          if (longint'(slot_y[p]) > hlim) slot_live[p] = 1'b0;
          if (slot_kind[p] != 2'd0) begin
            mag = slot_vx[p] < 0 ? -longint'(slot_vx[p]) : longint'(slot_vx[p]);
            if (mag > 32767) mag = 32767;
            if (longint'(slot_x[p]) + longint'(slot_wid[p]) * 256 > wlim)
              slot_vx[p] = 16'(-mag);
            if (slot_x[p] < 0) slot_vx[p] = 16'(mag);
          end
          if (slot_life[p] < 0) slot_live[p] = 1'b0;
        end
      end
      CmdRead: begin
        r.slot = w.rd; r.ok = slot_live[w.rd];
        r.pos_x = slot_x[w.rd]; r.pos_y = slot_y[w.rd];
        r.vel_x = slot_vx[w.rd]; r.vel_y = slot_vy[w.rd];
        r.life_left = slot_life[w.rd][16:0]; r.color = slot_color[w.rd];
        r.kind = slot_kind[w.rd]; r.width = slot_wid[w.rd]; r.height = slot_hgt[w.rd];
      end
      default: ;
    endcase
    n = 0;
    for (int p = 0; p < NumSlots; p++) n += slot_live[p];
    r.live_count = 7'(n);
    result_q.push_back(r);
  endfunction

  // Driver: predict on acceptance, then offer the next word or idle.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      send_gap      <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) run_command(on_bus);
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (send_gap > 0) begin
          send_gap      <= send_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (!calm && $urandom_range(0, 11) == 0) begin
          // random idle burst, starting with this one
          send_gap      <= $urandom_range(0, 5);
          s_axis_tvalid <= 1'b0;
        end else if (word_q.size() > 0) begin
          on_bus = word_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pack_word(on_bus);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // Monitor: check accepted result words, then pick the next ready value.
  always @(posedge clk_i) begin
    result_t e;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_gap      <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (result_q.size() == 0) begin
          $error("result word with no prediction waiting");
          errors++;
        end else begin
          e = result_q.pop_front();
          check_field("slot",       32'(e.slot),                   32'(m_axis_tdata[5:0]));
          check_field("ok",         32'(e.ok),                     32'(m_axis_tdata[6]));
          check_field("pos_x",      32'($unsigned(e.pos_x)),       32'(m_axis_tdata[26:7]));
          check_field("pos_y",      32'($unsigned(e.pos_y)),       32'(m_axis_tdata[46:27]));
          check_field("vel_x",      32'($unsigned(e.vel_x)),       32'(m_axis_tdata[62:47]));
          check_field("vel_y",      32'($unsigned(e.vel_y)),       32'(m_axis_tdata[78:63]));
          check_field("life_left",  32'($unsigned(e.life_left)),   32'(m_axis_tdata[95:79]));
          check_field("color",      32'(e.color),                  32'(m_axis_tdata[119:96]));
          check_field("kind",       32'(e.kind),                   32'(m_axis_tdata[121:120]));
          check_field("width",      32'(e.width),                  32'(m_axis_tdata[131:122]));
          check_field("height",     32'(e.height),                 32'(m_axis_tdata[141:132]));
          check_field("live_count", 32'(e.live_count),             32'(m_axis_tdata[148:142]));
        end
      end
      if (recv_gap > 0) begin
        recv_gap      <= recv_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        recv_gap      <= $urandom_range(0, 5);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: give up on a hung block.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Fully random bits in every field; callers narrow what matters.
  function automatic cmd_word_t any_word(logic [2:0] cmd);
    cmd_word_t w;
    w.cmd = cmd; w.x = 20'($urandom); w.y = 20'($urandom);
    w.vx = 16'($urandom); w.vy = 16'($urandom);
    w.life = 16'($urandom); w.color = 24'($urandom); w.mass = 12'($urandom);
    w.kind = 2'($urandom); w.wid = 10'($urandom); w.hgt = 10'($urandom);
    w.rd = 6'($urandom);
    return w;
  endfunction

  // Create word shaped so particles fly across and off a typical screen.
  function automatic cmd_word_t shaped_create();
    cmd_word_t w;
    w = any_word(CmdCreate);
    if ($urandom_range(0, 3) != 0) begin
      w.x    = 20'(int'($urandom_range(0, 900 * 256)) - 200 * 256);
      w.y    = 20'(int'($urandom_range(0, 700 * 256)) - 100 * 256);
      w.vx   = 16'(int'($urandom_range(0, 4096)) - 2048);
      w.vy   = 16'(int'($urandom_range(0, 4096)) - 2048);
      w.life = 16'($urandom_range(0, 12));
      w.wid  = 10'($urandom_range(0, 80));
    end
    return w;
  endfunction

  task automatic push(cmd_word_t w);
    word_q.push_back(w);
    issued++;
  endtask

  // Hold until the bench and the block have nothing in flight.
  task automatic drain();
    while (word_q.size() > 0 || s_axis_tvalid || result_q.size() > 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      RegGravity: gravity_q = val;
      RegWidth:   scr_w = val[11:0];
      default:    scr_h = val[11:0];
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [15:0] pick(logic [15:0] lo, logic [15:0] hi, logic [15:0] mid);
    case ($urandom_range(0, 3))
      0: return lo;
      1: return hi;
      default: return mid;
    endcase
  endfunction

  initial begin
    cmd_word_t w;
    int        k;
    errors = 0; issued = 0; calm = 1'b0; cycles = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0; m_axis_tready = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = RegGravity; cfg_wdata_i = '0;
    gravity_q = 16'sd26; scr_w = 12'd640; scr_h = 12'd480;
    clear_pool();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes, saturation, dead read, life underflow.
    w = any_word(CmdCreate);
    w.x = 20'sh7ffff; w.y = 20'sh7ffff; w.vx = 16'sh7fff; w.vy = 16'sh7fff;
    w.life = 16'd0; w.color = 24'd0; w.mass = 12'hfff; w.kind = 2'd1;
    w.wid = 10'h3ff; w.hgt = 10'd0;
    push(w);
    w = any_word(CmdCreate);
    w.x = -20'sh80000; w.y = -20'sh80000; w.vx = -16'sh8000; w.vy = -16'sh8000;
    w.life = 16'hffff; w.color = 24'hffffff; w.mass = 12'hfff; w.kind = 2'd3;
    w.wid = 10'd0; w.hgt = 10'h3ff;
    push(w);
    w = any_word(CmdRead); w.rd = 6'd0; push(w);
    push(any_word(CmdAdvance));
    w = any_word(CmdRead); w.rd = 6'd1; push(w);
    push(any_word(CmdCull));          // slot 0 life went negative, slot 1 bounces
    w = any_word(CmdRead); w.rd = 6'd0; push(w);
    w = any_word(CmdRead); w.rd = 6'd1; push(w);
    for (int c = CmdRead + 1; c < 8; c++) push(any_word(3'(c)));
    push(any_word(CmdClear));
    w = any_word(CmdRead); w.rd = 6'd1; push(w);
    drain();

    write_reg(RegGravity, 16'h8000);
    write_reg(RegWidth, 16'd1);
    write_reg(RegHeight, 16'd4095);
    // Fill every slot and overflow the pool; from here any slot may be read.
    for (int i = 0; i < NumSlots + 4; i++) push(shaped_create());
    w = any_word(CmdRead); w.rd = 6'd63; push(w);
    push(any_word(CmdAdvance));
    push(any_word(CmdCull));
    drain();

    // Random phases: new settings, then runs with random content, invalid codes included.
    while (issued < ItemTarget) begin
      if (issued > ItemTarget - 200) calm = 1'b1;
      write_reg(RegGravity, pick(16'h8000, 16'h7fff, 16'($urandom_range(0, 160)) - 16'd40));
      write_reg(RegWidth, pick(16'd1, 16'd4095, 16'($urandom_range(200, 900))));
      write_reg(RegHeight, pick(16'd1, 16'd4095, 16'($urandom_range(200, 700))));
      k = $urandom_range(20, 60);
      if ($urandom_range(0, 2) == 0) push(any_word(CmdClear));
      for (int i = 0; i < k; i++) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5:   push(shaped_create());
          6, 7, 8, 9:         push(any_word(CmdAdvance));
          10, 11, 12:         push(any_word(CmdCull));
          13, 14, 15, 16, 17: push(any_word(CmdRead));
          18:                 push(any_word(3'($urandom_range(CmdRead + 1, 7))));
          default:            push(any_word(CmdClear));
        endcase
      end
      drain();
    end

    repeat (80) @(posedge clk_i);
    if (errors == 0 && result_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      if (result_q.size() != 0) $error("%0d predicted results never arrived", result_q.size());
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
